@@ rtl/uhf_pkg.sv @@
package uhf_pkg;

  localparam int NUM_BINS = 1024;
  localparam int BIN_AW = 10;
  localparam int ACC_WIDTH = 48;
  localparam int SQ_WIDTH = 64;
  localparam int CNT_WIDTH = 32;
  localparam logic signed [ACC_WIDTH-1:0] UNIT_WEIGHT = 48'sd65536;
  localparam logic signed [ACC_WIDTH-1:0] ACC_MAX = {1'b0, {(ACC_WIDTH-1){1'b1}}};
  localparam logic signed [ACC_WIDTH-1:0] ACC_MIN = {1'b1, {(ACC_WIDTH-1){1'b0}}};

  localparam logic [2:0] REG_RANGE_MIN = 3'd0;
  localparam logic [2:0] REG_RANGE_MAX = 3'd1;
  localparam logic [2:0] REG_BIN_WIDTH = 3'd2;
  localparam logic [2:0] REG_INV_WIDTH = 3'd3;
  localparam logic [2:0] REG_BINS_USED = 3'd4;
  localparam logic [2:0] REG_TRACK_SQ = 3'd5;

  typedef enum logic [1:0] {
    OUT_IN_RANGE  = 2'd0,
    OUT_UNDERFLOW = 2'd1,
    OUT_OVERFLOW  = 2'd2,
    OUT_INVALID   = 2'd3
  } outcome_t;

  typedef enum logic [1:0] {
    ST_SUB,
    ST_MUL,
    ST_FIX,
    ST_PUSH
  } front_state_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_READ,
    BK_UPDATE,
    BK_WRITE
  } back_state_t;

  typedef struct packed {
    logic signed [31:0] sample;
    logic signed [31:0] weight;
    logic has_weight;
    logic invalid;
    logic batch_end;
  } in_word_t;

  typedef struct packed {
    logic [1:0] outcome;
    logic [9:0] bin_index;
    logic signed [47:0] class_weight;
    logic [63:0] class_sum_sq;
    logic [31:0] fill_count;
    logic [31:0] underflow_count;
    logic [31:0] overflow_count;
    logic [31:0] invalid_count;
    logic signed [47:0] weight_total;
    logic [63:0] total_sum_sq;
    logic batch_had_invalid;
  } out_word_t;

  typedef struct packed {
    outcome_t outcome;
    logic [BIN_AW-1:0] bin;
    logic signed [ACC_WIDTH-1:0] add_w;
    logic [SQ_WIDTH-1:0] add_sq;
    logic batch_end;
  } task_t;

  function automatic logic signed [ACC_WIDTH-1:0] acc_add(
    input logic signed [ACC_WIDTH-1:0] a, input logic signed [ACC_WIDTH-1:0] b);
    logic signed [ACC_WIDTH:0] s;
    s = {a[ACC_WIDTH-1], a} + {b[ACC_WIDTH-1], b};
    if (s[ACC_WIDTH] != s[ACC_WIDTH-1]) begin
      return s[ACC_WIDTH] ? ACC_MIN : ACC_MAX;
    end
    return s[ACC_WIDTH-1:0];
  endfunction

  function automatic logic [SQ_WIDTH-1:0] sq_add(
    input logic [SQ_WIDTH-1:0] a, input logic [SQ_WIDTH-1:0] b);
    logic [SQ_WIDTH:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[SQ_WIDTH] ? {SQ_WIDTH{1'b1}} : s[SQ_WIDTH-1:0];
  endfunction

  function automatic logic [CNT_WIDTH-1:0] cnt_inc(input logic [CNT_WIDTH-1:0] c);
    return (&c) ? c : c + 1'b1;
  endfunction

endpackage

@@ rtl/uhf_front.sv @@
module uhf_front import uhf_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  input  in_word_t in_word,
  output logic in_ready,
  input  logic signed [31:0] range_min,
  input  logic signed [31:0] range_max,
  input  logic [30:0] bin_width,
  input  logic [47:0] inv_bin_width,
  input  logic [10:0] bins_in_use,
  input  logic track_squares,
  output logic task_valid,
  output task_t task_word,
  input  logic task_ready
);

  front_state_t state, state_next;
  in_word_t item;
  logic busy;
  logic [32:0] diff;
  logic [10:0] nb;
  logic [56:0] prod_hi;
  logic [56:0] prod_lo;
  logic [63:0] wsq;
  logic [10:0] idx;
  logic [41:0] edge_hi;
  logic [41:0] edge_lo;
  outcome_t kind;

  logic [57:0] raw_sum;
  logic [33:0] raw;
  logic [10:0] idx_clamp;
  logic [10:0] idx_up;
  logic [10:0] idx_fix;
  logic [42:0] diff_ext;

  assign in_ready = !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_SUB;
      busy <= 1'b0;
    end else begin
      state <= state_next;
      if (in_valid && in_ready) begin
        busy <= 1'b1;
      end else if (state == ST_PUSH && task_ready) begin
        busy <= 1'b0;
      end
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_SUB:  if (busy) state_next = ST_MUL;
      ST_MUL:  state_next = ST_FIX;
      ST_FIX:  state_next = ST_PUSH;
      ST_PUSH: if (task_ready) state_next = ST_SUB;
      default: state_next = ST_SUB;
    endcase
  end

  assign raw_sum = {1'b0, prod_hi} + {25'd0, prod_lo[56:24]};
  assign raw = raw_sum[57:24];
  assign idx_clamp = (raw > {23'd0, nb - 11'd1}) ? nb - 11'd1 : raw[10:0];
  assign diff_ext = {10'd0, diff};

  always_comb begin
    idx_up = idx;
    if (idx + 11'd1 < nb && diff_ext >= {1'b0, edge_hi}) idx_up = idx + 11'd1;
    idx_fix = idx_up;
    if (idx_up == idx && idx != 11'd0 && diff_ext < {1'b0, edge_lo}) idx_fix = idx - 11'd1;
    else if (idx_up != idx && diff_ext < {1'b0, edge_hi}) idx_fix = idx;
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item <= in_word;
    end
    case (state)
      ST_SUB: begin
        diff <= 33'({item.sample[31], item.sample} - {range_min[31], range_min});
        nb <= (bins_in_use == 11'd0) ? 11'd1 :
              (bins_in_use > 11'(NUM_BINS)) ? 11'(NUM_BINS) : bins_in_use;
        if (item.invalid) kind <= OUT_INVALID;
        else if (item.sample < range_min) kind <= OUT_UNDERFLOW;
        else if (item.sample >= range_max) kind <= OUT_OVERFLOW;
        else kind <= OUT_IN_RANGE;
      end
      ST_MUL: begin
        prod_hi <= 57'(diff[32:0] * inv_bin_width[47:24]);
        prod_lo <= 57'(diff[32:0] * inv_bin_width[23:0]);
        wsq <= 64'($signed(item.weight) * $signed(item.weight));
      end
      ST_FIX: begin
        idx <= idx_clamp;
        edge_hi <= 42'((idx_clamp + 11'd1) * bin_width);
        edge_lo <= 42'(idx_clamp * bin_width);
      end
      default: ;
    endcase
  end

  // idx/edges used in push: fix applied combinationally from registered edges
  always_comb begin
    task_word.outcome = kind;
    task_word.bin = (kind == OUT_IN_RANGE) ? idx_fix[BIN_AW-1:0] : '0;
    task_word.add_w = item.has_weight ? ACC_WIDTH'(item.weight) : UNIT_WEIGHT;
    task_word.add_sq = (item.has_weight && track_squares) ? wsq : '0;
    task_word.batch_end = item.batch_end;
  end
  assign task_valid = (state == ST_PUSH);

endmodule

@@ rtl/uhf_queue.sv @@
module uhf_queue import uhf_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic wr_valid,
  input  task_t wr_word,
  output logic wr_ready,
  output logic rd_valid,
  output task_t rd_word,
  input  logic rd_ready
);

  task_t slots [2];
  logic wp, rp;
  logic [1:0] count;

  assign wr_ready = (count != 2'd2);
  assign rd_valid = (count != 2'd0);
  assign rd_word = slots[rp];

  always_ff @(posedge clk) begin
    if (wr_valid && wr_ready) slots[wp] <= wr_word;
    if (rst) begin
      wp <= 1'b0;
      rp <= 1'b0;
      count <= 2'd0;
    end else begin
      if (wr_valid && wr_ready) wp <= !wp;
      if (rd_valid && rd_ready) rp <= !rp;
      count <= count + 2'(wr_valid && wr_ready) - 2'(rd_valid && rd_ready);
    end
  end

endmodule

@@ rtl/uhf_back.sv @@
module uhf_back import uhf_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic task_valid,
  input  task_t task_word,
  output logic task_ready,
  output logic out_valid,
  output out_word_t out_word,
  input  logic out_ready
);

  back_state_t state, state_next;
  task_t cur;
  logic [ACC_WIDTH-1:0] wmem [NUM_BINS];
  logic [SQ_WIDTH-1:0] smem [NUM_BINS];
  logic [ACC_WIDTH-1:0] wrd;
  logic [SQ_WIDTH-1:0] srd;
  logic signed [ACC_WIDTH-1:0] wnew;
  logic [SQ_WIDTH-1:0] snew;
  logic clearing;
  logic [BIN_AW:0] clr_addr;

  logic [31:0] fills, unders, overs, invs;
  logic signed [ACC_WIDTH-1:0] tot_w, below_w, above_w;
  logic [SQ_WIDTH-1:0] tot_sq, below_sq, above_sq;
  logic flag;
  logic out_full;

  assign task_ready = (state == BK_IDLE) && !clearing && !out_full;
  assign out_valid = out_full;

  always_ff @(posedge clk) begin
    if (rst) state <= BK_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    case (state)
      BK_IDLE:   if (task_valid && task_ready) state_next = BK_READ;
      BK_READ:   state_next = BK_UPDATE;
      BK_UPDATE: state_next = BK_WRITE;
      BK_WRITE:  state_next = BK_IDLE;
      default:   state_next = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (clearing) begin
      wmem[clr_addr[BIN_AW-1:0]] <= '0;
      smem[clr_addr[BIN_AW-1:0]] <= '0;
    end else if (state == BK_WRITE && cur.outcome == OUT_IN_RANGE) begin
      wmem[cur.bin] <= wnew;
      smem[cur.bin] <= snew;
    end
    wrd <= wmem[cur.bin];
    srd <= smem[cur.bin];
    if (task_valid && task_ready) cur <= task_word;
    if (state == BK_UPDATE) begin
      wnew <= acc_add(wrd, cur.add_w);
      snew <= sq_add(srd, cur.add_sq);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
      fills <= '0; unders <= '0; overs <= '0; invs <= '0;
      tot_w <= '0; below_w <= '0; above_w <= '0;
      tot_sq <= '0; below_sq <= '0; above_sq <= '0;
      flag <= 1'b0;
      out_full <= 1'b0;
    end else begin
      if (clearing) begin
        clr_addr <= clr_addr + 1'b1;
        if (clr_addr == (BIN_AW+1)'(NUM_BINS - 1)) clearing <= 1'b0;
      end
      if (out_valid && out_ready) out_full <= 1'b0;
      if (state == BK_WRITE) begin
        out_full <= 1'b1;
        out_word.outcome <= cur.outcome;
        out_word.bin_index <= cur.bin;
        out_word.class_weight <= '0;
        out_word.class_sum_sq <= '0;
        out_word.fill_count <= fills;
        out_word.underflow_count <= unders;
        out_word.overflow_count <= overs;
        out_word.invalid_count <= invs;
        out_word.weight_total <= tot_w;
        out_word.total_sum_sq <= tot_sq;
        out_word.batch_had_invalid <= flag;
        case (cur.outcome)
          OUT_INVALID: begin
            invs <= cnt_inc(invs);
            out_word.invalid_count <= cnt_inc(invs);
            out_word.batch_had_invalid <= 1'b1;
            flag <= !cur.batch_end;
          end
          OUT_UNDERFLOW: begin
            unders <= cnt_inc(unders);
            below_w <= acc_add(below_w, cur.add_w);
            below_sq <= sq_add(below_sq, cur.add_sq);
            out_word.underflow_count <= cnt_inc(unders);
            out_word.class_weight <= acc_add(below_w, cur.add_w);
            out_word.class_sum_sq <= sq_add(below_sq, cur.add_sq);
            if (cur.batch_end) flag <= 1'b0;
          end
          OUT_OVERFLOW: begin
            overs <= cnt_inc(overs);
            above_w <= acc_add(above_w, cur.add_w);
            above_sq <= sq_add(above_sq, cur.add_sq);
            out_word.overflow_count <= cnt_inc(overs);
            out_word.class_weight <= acc_add(above_w, cur.add_w);
            out_word.class_sum_sq <= sq_add(above_sq, cur.add_sq);
            if (cur.batch_end) flag <= 1'b0;
          end
          default: begin
            fills <= cnt_inc(fills);
            tot_w <= acc_add(tot_w, cur.add_w);
            tot_sq <= sq_add(tot_sq, cur.add_sq);
            out_word.fill_count <= cnt_inc(fills);
            out_word.weight_total <= acc_add(tot_w, cur.add_w);
            out_word.total_sum_sq <= sq_add(tot_sq, cur.add_sq);
            out_word.class_weight <= wnew;
            out_word.class_sum_sq <= snew;
            if (cur.batch_end) flag <= 1'b0;
          end
        endcase
      end
    end
  end

endmodule

@@ rtl/uniform_histogram_fill.sv @@
// Weighted histogram with uniform bins. Push one sample word, pop one result
// word per sample. The front takes an item through subtract, reciprocal
// multiply, edge multiply, then the one-step fix as the task is handed on, and
// takes the next word only once it has handed the last one on, so it never
// holds more than one word. The back reads, updates and writes the bin store
// after taking a task and holds off the next task until the result word is
// popped; a two-entry queue between front and back lets each stall on its own.
// After reset the back clears the 1024-entry bin stores, one entry a cycle,
// before it takes any task; configuration writes are taken throughout.
module uniform_histogram_fill import uhf_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  output logic full,
  input  in_word_t data_in,
  output logic empty,
  input  logic pop,
  output out_word_t data_out,
  input  logic cfg_we,
  input  logic [2:0] cfg_index,
  input  logic [47:0] cfg_data
);

  logic signed [31:0] range_min, range_max;
  logic [30:0] bin_width;
  logic [47:0] inv_bin_width;
  logic [10:0] bins_in_use;
  logic track_squares;
  logic in_ready, f_valid, f_ready, q_valid, q_ready, o_valid;
  task_t f_word, q_word;

  always_ff @(posedge clk) begin
    if (rst) begin
      range_min <= 32'sd0;
      range_max <= 32'sd67108864;
      bin_width <= 31'd65536;
      inv_bin_width <= 48'd4294967296;
      bins_in_use <= 11'd1024;
      track_squares <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_RANGE_MIN: range_min <= cfg_data[31:0];
        REG_RANGE_MAX: range_max <= cfg_data[31:0];
        REG_BIN_WIDTH: bin_width <= cfg_data[30:0];
        REG_INV_WIDTH: inv_bin_width <= cfg_data;
        REG_BINS_USED: bins_in_use <= cfg_data[10:0];
        REG_TRACK_SQ:  track_squares <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign full = !in_ready;
  assign empty = !o_valid;

  uhf_front u_front (
    .clk, .rst, .in_valid(push), .in_word(data_in), .in_ready,
    .range_min, .range_max, .bin_width, .inv_bin_width, .bins_in_use,
    .track_squares, .task_valid(f_valid), .task_word(f_word), .task_ready(f_ready)
  );

  uhf_queue u_queue (
    .clk, .rst, .wr_valid(f_valid), .wr_word(f_word), .wr_ready(f_ready),
    .rd_valid(q_valid), .rd_word(q_word), .rd_ready(q_ready)
  );

  uhf_back u_back (
    .clk, .rst, .task_valid(q_valid), .task_word(q_word), .task_ready(q_ready),
    .out_valid(o_valid), .out_word(data_out), .out_ready(pop)
  );

endmodule

@@ sim/uniform_histogram_fill_test.sv @@
`timescale 1ns / 1ps

module uniform_histogram_fill_test;
  import uhf_pkg::*;

  class fill_scoreboard;
    logic signed [31:0] lo_edge, hi_edge;
    logic [30:0] width;
    logic [47:0] inv_width;
    logic [10:0] bins_used;
    logic track_sq;
    logic signed [47:0] bin_w [NUM_BINS];
    logic [63:0] bin_sq [NUM_BINS];
    logic [31:0] fills, unders, overs, invalids;
    logic signed [47:0] in_w, below_w, above_w;
    logic [63:0] in_sq, below_sq, above_sq;
    logic call_flag;
    out_word_t pending[$];
    int errors;

    function void clear();
      lo_edge = 0;
      hi_edge = 32'sd67108864;
      width = 31'd65536;
      inv_width = 48'h1_0000_0000;
      bins_used = 11'd1024;
      track_sq = 0;
      foreach (bin_w[i]) begin
        bin_w[i] = 0;
        bin_sq[i] = 0;
      end
      fills = 0; unders = 0; overs = 0; invalids = 0;
      in_w = 0; below_w = 0; above_w = 0;
      in_sq = 0; below_sq = 0; above_sq = 0;
      call_flag = 0;
      errors = 0;
    endfunction

    function void set_reg(logic [2:0] idx, logic [47:0] v);
      case (idx)
        REG_RANGE_MIN: lo_edge = v[31:0];
        REG_RANGE_MAX: hi_edge = v[31:0];
        REG_BIN_WIDTH: width = v[30:0];
        REG_INV_WIDTH: inv_width = v;
        REG_BINS_USED: bins_used = v[10:0];
        REG_TRACK_SQ: track_sq = v[0];
        default: ;
      endcase
    endfunction

    function logic signed [47:0] sat_add(logic signed [47:0] a, logic signed [47:0] b);
      logic signed [48:0] s;
      s = $signed({a[47], a}) + $signed({b[47], b});
      if (s > $signed({1'b0, ACC_MAX})) return ACC_MAX;
      if (s < $signed({1'b1, ACC_MIN})) return ACC_MIN;
      return s[47:0];
    endfunction

    function logic [63:0] sat_sq(logic [63:0] a, logic [63:0] b);
      logic [64:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[64] ? '1 : s[63:0];
    endfunction

    function logic [31:0] bump(logic [31:0] c);
      return (&c) ? c : c + 1;
    endfunction

    function void note_sample(in_word_t w);
      out_word_t r;
      logic signed [47:0] add_w;
      logic [63:0] add_sq, diff, nb, raw, idx;
      logic signed [63:0] wv;
      r = '0;
      add_w = w.has_weight ? 48'(w.weight) : UNIT_WEIGHT;
      wv = w.weight;
      add_sq = (w.has_weight && track_sq) ? 64'(wv * wv) : 64'd0;
      if (w.invalid) begin
        r.outcome = OUT_INVALID;
        invalids = bump(invalids);
        call_flag = 1;
      end else if (w.sample < lo_edge) begin
        r.outcome = OUT_UNDERFLOW;
        below_w = sat_add(below_w, add_w);
        below_sq = sat_sq(below_sq, add_sq);
        unders = bump(unders);
        r.class_weight = below_w;
        r.class_sum_sq = below_sq;
      end else if (w.sample >= hi_edge) begin
        r.outcome = OUT_OVERFLOW;
        above_w = sat_add(above_w, add_w);
        above_sq = sat_sq(above_sq, add_sq);
        overs = bump(overs);
        r.class_weight = above_w;
        r.class_sum_sq = above_sq;
      end else begin
        diff = 64'($signed(64'(w.sample)) - $signed(64'(lo_edge)));
        nb = bins_used;
        if (nb == 0) nb = 1;
        if (nb > NUM_BINS) nb = NUM_BINS;
        raw = (diff * (inv_width >> 24) + ((diff * inv_width[23:0]) >> 24)) >> 24;
        idx = raw > nb - 1 ? nb - 1 : raw;
        if (idx + 1 < nb && diff >= (idx + 1) * width) idx++;
        if (idx > 0 && diff < idx * width) idx--;
        r.outcome = OUT_IN_RANGE;
        r.bin_index = idx[9:0];
        bin_w[idx] = sat_add(bin_w[idx], add_w);
        bin_sq[idx] = sat_sq(bin_sq[idx], add_sq);
        in_w = sat_add(in_w, add_w);
        in_sq = sat_sq(in_sq, add_sq);
        fills = bump(fills);
        r.class_weight = bin_w[idx];
        r.class_sum_sq = bin_sq[idx];
      end
      r.fill_count = fills;
      r.underflow_count = unders;
      r.overflow_count = overs;
      r.invalid_count = invalids;
      r.weight_total = in_w;
      r.total_sum_sq = in_sq;
      r.batch_had_invalid = call_flag;
      if (w.batch_end) call_flag = 0;
      pending.push_back(r);
    endfunction

    function void check_result(out_word_t a);
      out_word_t e;
      if (pending.size() == 0) begin
        $error("unexpected result word %h", a);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (a.outcome !== e.outcome) begin
        $error("outcome exp %0d got %0d", e.outcome, a.outcome); errors++;
      end
      if (a.bin_index !== e.bin_index) begin
        $error("bin_index exp %0d got %0d", e.bin_index, a.bin_index); errors++;
      end
      if (a.class_weight !== e.class_weight) begin
        $error("class_weight exp %0d got %0d", e.class_weight, a.class_weight); errors++;
      end
      if (a.class_sum_sq !== e.class_sum_sq) begin
        $error("class_sum_sq exp %0d got %0d", e.class_sum_sq, a.class_sum_sq); errors++;
      end
      if (a.fill_count !== e.fill_count) begin
        $error("fill_count exp %0d got %0d", e.fill_count, a.fill_count); errors++;
      end
      if (a.underflow_count !== e.underflow_count) begin
        $error("underflow_count exp %0d got %0d", e.underflow_count, a.underflow_count);
        errors++;
      end
      if (a.overflow_count !== e.overflow_count) begin
        $error("overflow_count exp %0d got %0d", e.overflow_count, a.overflow_count);
        errors++;
      end
      if (a.invalid_count !== e.invalid_count) begin
        $error("invalid_count exp %0d got %0d", e.invalid_count, a.invalid_count); errors++;
      end
      if (a.weight_total !== e.weight_total) begin
        $error("weight_total exp %0d got %0d", e.weight_total, a.weight_total); errors++;
      end
      if (a.total_sum_sq !== e.total_sum_sq) begin
        $error("total_sum_sq exp %0d got %0d", e.total_sum_sq, a.total_sum_sq); errors++;
      end
      if (a.batch_had_invalid !== e.batch_had_invalid) begin
        $error("batch_had_invalid exp %0d got %0d", e.batch_had_invalid,
               a.batch_had_invalid);
        errors++;
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst = 1;
  logic push = 0;
  logic full;
  in_word_t data_in = '0;
  logic empty;
  logic pop = 0;
  out_word_t data_out;
  logic cfg_we = 0;
  logic [2:0] cfg_index = '0;
  logic [47:0] cfg_data = '0;

  int send_idle = 0;
  int take_idle = 0;
  fill_scoreboard hist_sb;

  uniform_histogram_fill u_top (
    .clk(clk), .rst(rst), .push(push), .full(full), .data_in(data_in),
    .empty(empty), .pop(pop), .data_out(data_out),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #6 clk = ~clk;

  // result side: pop decided each edge, check when accepted
  always @(posedge clk) begin
    if (!rst) begin
      if (pop && !empty) hist_sb.check_result(data_out);
      pop <= ($urandom_range(99) >= take_idle);
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [47:0] v);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= v;
    @(posedge clk);
    hist_sb.set_reg(idx, v);
  endtask

  task automatic send_sample(in_word_t w);
    while ($urandom_range(99) < send_idle) begin
      push <= 0;
      @(posedge clk);
    end
    push <= 1;
    data_in <= w;
    @(posedge clk);
    while (full) @(posedge clk);
    hist_sb.note_sample(w);
  endtask

  task automatic drain();
    push <= 0;
    while (hist_sb.pending.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  function automatic logic [31:0] pick_sample(logic signed [31:0] lo, logic signed [31:0] hi);
    case ($urandom_range(9))
      0: return $urandom;
      1: return lo + $urandom_range(3) - 2;
      2: return hi + $urandom_range(3) - 2;
      default: return lo + 32'($urandom % (64'(hi - lo) > 0 ? 64'(hi - lo) : 1));
    endcase
  endfunction

  task automatic random_phase(int n);
    in_word_t w;
    for (int i = 0; i < n; i++) begin
      w.sample = pick_sample(hist_sb.lo_edge, hist_sb.hi_edge);
      case ($urandom_range(5))
        0: w.weight = $urandom;
        1: w.weight = $urandom_range(1) ? 32'h7fffffff : 32'h80000000;
        default: w.weight = $signed(32'($urandom_range(400000))) - 200000;
      endcase
      w.has_weight = $urandom_range(3) != 0;
      w.invalid = $urandom_range(15) == 0;
      w.batch_end = $urandom_range(7) == 0;
      send_sample(w);
    end
  endtask

  task automatic set_range(logic signed [31:0] lo, logic signed [31:0] hi,
                           logic [30:0] wd, logic [47:0] iw, logic [10:0] nb, logic sq);
    write_reg(REG_RANGE_MIN, 48'(unsigned'(lo)));
    write_reg(REG_RANGE_MAX, 48'(unsigned'(hi)));
    write_reg(REG_BIN_WIDTH, 48'(wd));
    write_reg(REG_INV_WIDTH, iw);
    write_reg(REG_BINS_USED, 48'(nb));
    write_reg(REG_TRACK_SQ, 48'(sq));
    cfg_we <= 0;
  endtask

  initial begin
    in_word_t w;
    hist_sb = new();
    hist_sb.clear();
    repeat (2) @(posedge clk);
    rst <= 0;
    send_idle = 36;
    take_idle = 85;
    set_range(0, 32'sd67108864, 31'd65536, 48'h1_0000_0000, 11'd1024, 1);
    // directed words
    w = '0;
    w.sample = 32'h80000000; w.weight = 32'h7fffffff; w.has_weight = 1; send_sample(w);
    w.sample = 32'h7fffffff; w.weight = 32'h80000000; send_sample(w);
    w.sample = 0; w.weight = 32'hffffffff; send_sample(w);
    w.sample = 32'sd67108863; w.weight = 32'h7fffffff; send_sample(w);
    w.sample = 32'sd67108864; send_sample(w);
    w.sample = 32'sd65536; w.has_weight = 0; send_sample(w);
    w.sample = 32'sd65535; send_sample(w);
    w.invalid = 1; send_sample(w);
    w.invalid = 0; w.batch_end = 1; send_sample(w);
    w.batch_end = 0; send_sample(w);
    for (int i = 0; i < 4; i++) begin
      w.sample = 5 * 65536; w.weight = 32'h7fffffff; w.has_weight = 1; send_sample(w);
    end
    drain();
    // zero inverse width, zero bins in use, width not a power of two
    set_range(-32'sd1000000, 32'sd3000000, 31'd100000, 48'd0, 11'd0, 1);
    w.sample = 32'sd250000; send_sample(w);
    w.sample = -32'sd1000000; send_sample(w);
    drain();
    set_range(-32'sd1000000, 32'sd3000000, 31'd100000, 48'd42949673, 11'd2047, 0);
    w.sample = 32'sd2999999; send_sample(w);
    w.sample = -32'sd900000; send_sample(w);
    drain();
    // inverted range
    set_range(32'sd100, -32'sd100, 31'h7fffffff, 48'hffff_ffff_ffff, 11'd1, 1);
    w.sample = 0; send_sample(w);
    w.sample = 32'sd100; send_sample(w);
    random_phase(100);
    drain();
    set_range(-32'sd65536 * 32, 32'sd65536 * 32, 31'd65536 / 4, 48'h4_0000_0000, 11'd256, 1);
    random_phase(500);
    drain();
    send_idle = 85;
    take_idle = 36;
    set_range(-32'sd3000, 32'sd5000, 31'd3, 48'd1431655765, 11'd1024, 0);
    random_phase(500);
    drain();
    send_idle = 0;
    take_idle = 0;
    set_range(32'h80000000, 32'h7fffffff, 31'h400000, 48'd1024, 11'd1024, 1);
    random_phase(600);
    drain();
    if (hist_sb.errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("Some tests failed");
    $finish;
  end

endmodule

@@ sim.f @@
rtl/uhf_pkg.sv
rtl/uhf_front.sv
rtl/uhf_queue.sv
rtl/uhf_back.sv
rtl/uniform_histogram_fill.sv
sim/uniform_histogram_fill_test.sv
